### sv/rsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// constant for the ray / segment intersection pipeline
// ----------------------------------------------------------------------------
package rsi_pkg;

  // integer bits of the ray parameter t (unsigned Q8.F)
  localparam int unsigned IntBits = 8;

endpackage

### sv/ray_segment_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_segment_intersection
// pipelined 2d ray against wall segment test with fixed point t and u
// ----------------------------------------------------------------------------
// usage
//   slave channel carries one ray (start, end) and one segment (a, b) per
//   transaction, eight signed Q16.4 coordinates packed in tdata
//   master channel returns one result per transaction: hit flag in tuser,
//   t (unsigned Q8.F, saturating) and u (unsigned Q1.F, at most one) in tdata
//   both are zero when there is no hit
// pipeline and throughput
//   an input transaction reaches the master side through four arithmetic
//   stages, one restoring divider stage per quotient bit of t and an output
//   register; one transaction per cycle sustained unless a result is held
//   back by tready; t and u dividers run side by side
// reset
//   rst_ni clears every valid bit; data registers are not reset
// stall
//   the whole pipeline holds while a result waits and tready is low, so
//   nothing is lost or repeated; tready on the slave side follows that
// ----------------------------------------------------------------------------
module ray_segment_intersection #(
  parameter int unsigned COORD_WIDTH     = 20,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // ray_start_x, ray_start_y, ray_end_x, ray_end_y,
  // seg_a_x, seg_a_y, seg_b_x, seg_b_y (lowest first), zero padded to bytes
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // ray_param (IntBits+F bits), seg_param (F+1 bits), zero padded to bytes
  output logic [((rsi_pkg::IntBits+2*PARAM_FRAC_BITS+1+7)/8)*8-1:0] m_axis_tdata_o,
  // hit
  output logic m_axis_tuser_o
);

  localparam int unsigned C   = COORD_WIDTH;
  localparam int unsigned F   = PARAM_FRAC_BITS;
  localparam int unsigned IB  = rsi_pkg::IntBits;
  localparam int unsigned DW  = C + 1;        // coordinate differences
  localparam int unsigned PW  = 2 * DW;       // products
  localparam int unsigned SW  = PW + 1;       // cross products
  localparam int unsigned RW  = SW + IB;      // divider remainder
  localparam int unsigned N   = IB + F;       // quotient bits, divider stages
  localparam int unsigned TW  = N;            // ray_param width
  localparam int unsigned UW  = F + 1;        // seg_param width
  localparam int unsigned OW  = ((TW + UW + 7) / 8) * 8;

  // global advance: the pipeline moves unless a result is blocked
  logic adv;
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // --------------------------------------------------------------------------
  // stage a: differences
  // --------------------------------------------------------------------------
  logic signed [C-1:0] rx1, ry1, rx2, ry2, wx1, wy1, wx2, wy2;
  assign rx1 = s_axis_tdata_i[0*C +: C];
  assign ry1 = s_axis_tdata_i[1*C +: C];
  assign rx2 = s_axis_tdata_i[2*C +: C];
  assign ry2 = s_axis_tdata_i[3*C +: C];
  assign wx1 = s_axis_tdata_i[4*C +: C];
  assign wy1 = s_axis_tdata_i[5*C +: C];
  assign wx2 = s_axis_tdata_i[6*C +: C];
  assign wy2 = s_axis_tdata_i[7*C +: C];

  logic              va_q;
  logic signed [DW-1:0] drx_q, dry_q, dwx_q, dwy_q, sx_q, sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      drx_q <= DW'(rx1) - DW'(rx2);
      dry_q <= DW'(ry1) - DW'(ry2);
      dwx_q <= DW'(wx1) - DW'(wx2);
      dwy_q <= DW'(wy1) - DW'(wy2);
      sx_q  <= DW'(rx1) - DW'(wx1);
      sy_q  <= DW'(ry1) - DW'(wy1);
    end
  end

  // --------------------------------------------------------------------------
  // stage b: six products
  // --------------------------------------------------------------------------
  logic              vb_q;
  logic signed [PW-1:0] pd1_q, pd2_q, pt1_q, pt2_q, pu1_q, pu2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd1_q <= PW'(drx_q) * PW'(dwy_q);
      pd2_q <= PW'(dry_q) * PW'(dwx_q);
      pt1_q <= PW'(sx_q)  * PW'(dwy_q);
      pt2_q <= PW'(sy_q)  * PW'(dwx_q);
      pu1_q <= PW'(dry_q) * PW'(sx_q);
      pu2_q <= PW'(drx_q) * PW'(sy_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage c: determinant and numerators
  // --------------------------------------------------------------------------
  logic              vc_q;
  logic signed [SW-1:0] den_q, tn_q, un_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q <= SW'(pd1_q) - SW'(pd2_q);
      tn_q  <= SW'(pt1_q) - SW'(pt2_q);
      un_q  <= SW'(pu1_q) - SW'(pu2_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage d: magnitudes, hit test, saturation of t
  // --------------------------------------------------------------------------
  logic [SW-1:0] dmag, tmag, umag;
  logic          dneg, hit_d, sat_d;

  always_comb begin
    dneg  = den_q[SW-1];
    dmag  = dneg ? SW'(-den_q) : SW'(den_q);
    tmag  = tn_q[SW-1] ? SW'(-tn_q) : SW'(tn_q);
    umag  = un_q[SW-1] ? SW'(-un_q) : SW'(un_q);
    hit_d = (den_q != '0)
         && (tn_q == '0 || tn_q[SW-1] == dneg)
         && (un_q == '0 || un_q[SW-1] == dneg)
         && (umag <= dmag);
    // t of 2^IntBits or more saturates
    sat_d = RW'(tmag) >= (RW'(dmag) << IB);
  end

  // divider pipeline, index 0 is the stage d register
  logic          dv_q   [N+1];
  logic          hit_q  [N+1];
  logic          sat_q  [N+1];
  logic [SW-1:0] dd_q   [N+1];
  logic [RW-1:0] rt_q   [N+1];
  logic [RW-1:0] ru_q   [N+1];
  logic [N-1:0]  qt_q   [N+1];
  logic [N-1:0]  qu_q   [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q[0] <= hit_d;
      sat_q[0] <= sat_d;
      dd_q[0]  <= dmag;
      rt_q[0]  <= RW'(tmag);
      ru_q[0]  <= RW'(umag);
      qt_q[0]  <= '0;
      qu_q[0]  <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // restoring division, one quotient bit per stage for t and u
  // integer stages compare against the shifted divisor, fraction stages
  // double the remainder
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < N; j++) begin : g_div
    localparam int unsigned SH = (j < IB) ? (IB - 1 - j) : 0;
    localparam bit          FR = (j >= IB);

    logic [RW-1:0] tin, uin, dvs;
    logic          tge, uge;

    always_comb begin
      tin = FR ? (rt_q[j] << 1) : rt_q[j];
      uin = FR ? (ru_q[j] << 1) : ru_q[j];
      dvs = RW'(dd_q[j]) << SH;
      tge = tin >= dvs;
      uge = uin >= dvs;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        hit_q[j+1] <= hit_q[j];
        sat_q[j+1] <= sat_q[j];
        dd_q[j+1]  <= dd_q[j];
        rt_q[j+1]  <= tge ? (tin - dvs) : tin;
        ru_q[j+1]  <= uge ? (uin - dvs) : uin;
        qt_q[j+1]  <= {qt_q[j][N-2:0], tge};
        qu_q[j+1]  <= {qu_q[j][N-2:0], uge};
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic          ov_q;
  logic          ohit_q;
  logic [TW-1:0] ot_q;
  logic [UW-1:0] ou_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= dv_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ohit_q <= hit_q[N];
      if (!hit_q[N]) begin
        ot_q <= '0;
        ou_q <= '0;
      end else begin
        ot_q <= sat_q[N] ? {TW{1'b1}} : qt_q[N];
        ou_q <= qu_q[N][UW-1:0];
      end
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = ohit_q;
  assign m_axis_tdata_o  = OW'({ou_q, ot_q});

endmodule
